// ===== rtl/sfr_pkg.sv =====
// Shared types and constants for the shape fill rasterizer.
// Holds the request and response word layouts, command codes and CSR indexes.
// No dependencies.
`timescale 1ns / 1ps

package sfr_pkg;

   // command codes carried in the request word
   localparam logic [1:0] CMD_CIRCLE = 2'd0;
   localparam logic [1:0] CMD_RECT   = 2'd1;
   localparam logic [1:0] CMD_READ   = 2'd2;

   // result kinds carried in the response word
   localparam logic RESULT_DRAW = 1'b0;
   localparam logic RESULT_READ = 1'b1;

   // configuration register indexes
   localparam int          CSR_INDEX_W      = 2;
   localparam int          CSR_DATA_W       = 9;
   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
   localparam logic [CSR_DATA_W-1:0]  FRAME_SIZE_RESET = 9'd256;

   // saturation limit of the pixel counter
   localparam logic [16:0] COUNT_MAX = 17'h1FFFF;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] pos_x;
      logic [7:0] pos_y;
      logic [8:0] size_a;
      logic [8:0] size_b;
      logic [7:0] fill_red;
      logic [7:0] fill_green;
      logic [7:0] fill_blue;
   } sfr_req_type;

   typedef struct packed {
      logic        result_kind;
      logic [16:0] pixels_written;
      logic [7:0]  pixel_red;
      logic [7:0]  pixel_green;
      logic [7:0]  pixel_blue;
   } sfr_rsp_type;

endpackage

// ===== rtl/shape_fill_rasterizer.sv =====
// Shape fill rasterizer: circle and rectangle fill into an on-chip RGB frame store.
// Draw: one pixel a cycle over the clipped bounding box, with a row step between rows,
// through the shared squarer; one command at a time.
// The squarer and the single frame store write port set the one-pixel-per-cycle walk.
// Reset (synchronous) starts a clearing pass of all MAX_WIDTH * MAX_HEIGHT words that
// blacks out the frame store; requests stall until it ends, CSR writes are still taken.
`timescale 1ns / 1ps

module shape_fill_rasterizer #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  sfr_pkg::sfr_req_type         req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output sfr_pkg::sfr_rsp_type         rsp_data,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [sfr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [sfr_pkg::CSR_DATA_W-1:0]  csr_data
);
   import sfr_pkg::*;

   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   // sequencer states
   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_SETUP = 3'd2;
   localparam logic [2:0] S_ROW   = 3'd3;
   localparam logic [2:0] S_PIX   = 3'd4;
   localparam logic [2:0] S_READ  = 3'd5;
   localparam logic [2:0] S_DONE  = 3'd6;

   // frame store
   logic [23:0] mem [DEPTH];

   logic [2:0]    state_ff, state_in;
   logic [AW-1:0] clr_addr_ff, clr_addr_in;
   logic [8:0]    frame_width_ff, frame_height_ff;

   // latched command
   logic [1:0]  cmd_ff, cmd_in;
   logic [7:0]  px_ff, px_in, py_ff, py_in;
   logic [8:0]  sa_ff, sa_in, sb_ff, sb_in;
   logic [23:0] colour_ff, colour_in;

   // walk state
   logic [9:0]    x_ff, x_in, y_ff, y_in;
   logic [9:0]    x0_ff, x0_in, x1_ff, x1_in, y1_ff, y1_in;
   logic          round_ff, round_in;
   logic [17:0]   rr_ff, rr_in, jj_ff, jj_in;
   logic [AW-1:0] row_base_ff, row_base_in;
   logic [16:0]   count_ff, count_in;

   // pixel test stage
   logic          p_valid_ff, p_valid_in;
   logic [AW-1:0] p_addr_ff, p_addr_in;
   logic [17:0]   p_sq_ff, p_sq_in;

   logic [23:0] rd_data_ff;

   logic        rsp_valid_ff, rsp_valid_in;
   sfr_rsp_type rsp_data_ff, rsp_data_in;

   // shared squarer
   logic signed [9:0]  sq_op;
   logic signed [19:0] sq_full;
   logic [17:0]        sq;

   logic [9:0]  eff_w, eff_h;
   logic [10:0] lo_x, lo_y;
   logic [9:0]  bx0, by0, hx, hy, bx1, by1;
   logic        box_empty;
   logic        in_frame;
   logic [AW-1:0] rd_addr;
   logic [18:0] dist_sum;
   logic        in_circle;
   logic        pix_we;
   logic        mem_we;
   logic [AW-1:0] mem_waddr;
   logic [23:0] mem_wdata;
   logic        req_accept;
   logic        rsp_load;

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   // clamp frame size to the store dimensions
   assign eff_w = (32'(frame_width_ff) > MAX_WIDTH) ? 10'(MAX_WIDTH) : {1'b0, frame_width_ff};
   assign eff_h = (32'(frame_height_ff) > MAX_HEIGHT) ? 10'(MAX_HEIGHT) :
                  {1'b0, frame_height_ff};

   // bounding box, clipped to the frame
   assign lo_x = {3'b000, px_ff} - {2'b00, sa_ff};
   assign lo_y = {3'b000, py_ff} - {2'b00, sa_ff};
   assign hx   = {2'b00, px_ff} + {1'b0, sa_ff};
   assign hy   = (cmd_ff == CMD_CIRCLE) ? ({2'b00, py_ff} + {1'b0, sa_ff}) :
                                          ({2'b00, py_ff} + {1'b0, sb_ff});
   always_comb begin
      if (cmd_ff == CMD_CIRCLE) begin
         bx0 = lo_x[10] ? 10'd0 : lo_x[9:0];
         by0 = lo_y[10] ? 10'd0 : lo_y[9:0];
      end else begin
         bx0 = {2'b00, px_ff};
         by0 = {2'b00, py_ff};
      end
   end
   assign bx1       = (hx < eff_w) ? hx : eff_w;
   assign by1       = (hy < eff_h) ? hy : eff_h;
   assign box_empty = (bx0 >= bx1) || (by0 >= by1);

   // read address and frame check
   assign in_frame = ({2'b00, px_ff} < eff_w) && ({2'b00, py_ff} < eff_h);
   assign rd_addr  = AW'(32'(py_ff) * MAX_WIDTH + 32'(px_ff));

   // select squarer operand: radius in setup, row offset per row, column offset per pixel
   always_comb begin
      unique case (state_ff)
         S_SETUP: sq_op = $signed({1'b0, sa_ff});
         S_ROW:   sq_op = $signed(10'(y_ff - {2'b00, py_ff}));
         default: sq_op = $signed(10'(x_ff - {2'b00, px_ff}));
      endcase
   end
   assign sq_full = sq_op * sq_op;
   assign sq      = sq_full[17:0];

   // pixel test: inside the circle, or any pixel of a rectangle
   assign dist_sum  = {1'b0, p_sq_ff} + {1'b0, jj_ff};
   assign in_circle = !round_ff || (dist_sum < {1'b0, rr_ff});
   assign pix_we    = p_valid_ff && in_circle;

   // sequencer
   always_comb begin
      state_in    = state_ff;
      clr_addr_in = clr_addr_ff;
      cmd_in      = cmd_ff;
      px_in       = px_ff;
      py_in       = py_ff;
      sa_in       = sa_ff;
      sb_in       = sb_ff;
      colour_in   = colour_ff;
      x_in        = x_ff;
      y_in        = y_ff;
      x0_in       = x0_ff;
      x1_in       = x1_ff;
      y1_in       = y1_ff;
      round_in    = round_ff;
      rr_in       = rr_ff;
      jj_in       = jj_ff;
      row_base_in = row_base_ff;
      count_in    = count_ff;
      p_valid_in  = (state_ff == S_PIX);
      p_addr_in   = AW'(row_base_ff + AW'(x_ff));
      p_sq_in     = sq;
      rsp_load    = 1'b0;
      rsp_data_in = rsp_data_ff;

      unique case (state_ff)
         S_CLEAR: begin
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == AW'(DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_accept) begin
               cmd_in    = req_data.cmd;
               px_in     = req_data.pos_x;
               py_in     = req_data.pos_y;
               sa_in     = req_data.size_a;
               sb_in     = req_data.size_b;
               colour_in = {req_data.fill_red, req_data.fill_green, req_data.fill_blue};
               count_in  = '0;
               priority case (req_data.cmd)
                  CMD_CIRCLE, CMD_RECT: state_in = S_SETUP;
                  CMD_READ:             state_in = S_READ;
                  default:              state_in = S_DONE;
               endcase
            end
         end
         S_SETUP: begin
            rr_in    = sq;
            round_in = (cmd_ff == CMD_CIRCLE);
            x0_in    = bx0;
            x1_in    = bx1;
            y1_in    = by1;
            y_in     = by0;
            state_in = box_empty ? S_DONE : S_ROW;
         end
         S_ROW: begin
            if (y_ff == y1_ff) begin
               state_in = S_DONE;
            end else begin
               jj_in       = sq;
               row_base_in = AW'(32'(y_ff) * MAX_WIDTH);
               x_in        = x0_ff;
               state_in    = S_PIX;
            end
         end
         S_PIX: begin
            x_in = x_ff + 1'b1;
            if (x_ff + 1'b1 == x1_ff) begin
               y_in     = y_ff + 1'b1;
               state_in = S_ROW;
            end
         end
         S_READ: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load                   = 1'b1;
               rsp_data_in                = '0;
               rsp_data_in.result_kind    = (cmd_ff == CMD_READ) ? RESULT_READ : RESULT_DRAW;
               if (cmd_ff == CMD_CIRCLE || cmd_ff == CMD_RECT) begin
                  rsp_data_in.pixels_written = count_ff;
               end
               if (cmd_ff == CMD_READ && in_frame) begin
                  rsp_data_in.pixel_red   = rd_data_ff[23:16];
                  rsp_data_in.pixel_green = rd_data_ff[15:8];
                  rsp_data_in.pixel_blue  = rd_data_ff[7:0];
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // count covered pixels, saturating
      if (pix_we && count_ff != COUNT_MAX) begin
         count_in = count_ff + 1'b1;
      end
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   // frame store write port: clearing pass or covered pixel
   assign mem_we    = (state_ff == S_CLEAR) || pix_we;
   assign mem_waddr = (state_ff == S_CLEAR) ? clr_addr_ff : p_addr_ff;
   assign mem_wdata = (state_ff == S_CLEAR) ? 24'd0 : colour_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (state_ff == S_READ && in_frame) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_CLEAR;
         clr_addr_ff     <= '0;
         p_valid_ff      <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         frame_width_ff  <= FRAME_SIZE_RESET;
         frame_height_ff <= FRAME_SIZE_RESET;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         p_valid_ff   <= p_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            if (csr_index == REG_FRAME_WIDTH) begin
               frame_width_ff <= csr_data;
            end else if (csr_index == REG_FRAME_HEIGHT) begin
               frame_height_ff <= csr_data;
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      px_ff       <= px_in;
      py_ff       <= py_in;
      sa_ff       <= sa_in;
      sb_ff       <= sb_in;
      colour_ff   <= colour_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      x0_ff       <= x0_in;
      x1_ff       <= x1_in;
      y1_ff       <= y1_in;
      round_ff    <= round_in;
      rr_ff       <= rr_in;
      jj_ff       <= jj_in;
      row_base_ff <= row_base_in;
      count_ff    <= count_in;
      p_addr_ff   <= p_addr_in;
      p_sq_ff     <= p_sq_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// ===== rtl/sfr_checker.sv =====
// Port-level checks for the shape fill rasterizer, bound to the top level.
// Depends on sfr_pkg for the response word layout.
`timescale 1ns / 1ps

module sfr_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input sfr_pkg::sfr_rsp_type rsp_data
);
   import sfr_pkg::*;

   // keep a stalled response word valid
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response word dropped while stalled");

   // stall the next request after one is taken
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while a command is in progress");

   // block requests right after reset, as the clearing pass starts
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("request port open right after reset");

   // reads carry no pixel count, draws carry no colour
   a_read_no_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.result_kind == RESULT_READ |-> rsp_data.pixels_written == 17'd0)
      else $error("read word with nonzero pixel count");

   a_draw_no_colour: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.result_kind == RESULT_DRAW |->
         rsp_data.pixel_red == 8'd0 && rsp_data.pixel_green == 8'd0 &&
         rsp_data.pixel_blue == 8'd0)
      else $error("draw word with nonzero colour");

endmodule

bind shape_fill_rasterizer sfr_checker u_sfr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
